// ===== rtl/ctl_tok_pkg.sv =====
// Package for the configuration text tokenizer: result kinds, character codes,
// the result entry type and default sizes. Depends on nothing.
package ctl_tok_pkg;

  typedef enum logic [1:0] {
    KindByte = 2'd0,
    KindEow  = 2'd1,
    KindEol  = 2'd2,
    KindEoi  = 2'd3
  } kind_e;

  localparam logic [7:0] ChNul   = 8'h00;
  localparam logic [7:0] ChTab   = 8'h09;
  localparam logic [7:0] ChLf    = 8'h0A;
  localparam logic [7:0] ChCr    = 8'h0D;
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChQuote = 8'h22;
  localparam logic [7:0] ChComma = 8'h2C;
  localparam logic [7:0] ChSemi  = 8'h3B;
  localparam logic [7:0] LenMax  = 8'hFF;

  localparam int unsigned LineCountBitsDef = 16;
  localparam int unsigned QueueDepth       = 8;
  localparam int unsigned MaxPerByte       = 3;

  typedef struct packed {
    kind_e       kind;
    logic [7:0]  word_byte;
    logic [7:0]  word_length;
    logic [15:0] line_number;
    logic        last;
  } res_t;

endpackage

// ===== rtl/config_text_line_tokenizer_top.sv =====
// Top level of the configuration text tokenizer: byte classifier, line state
// and an eight-entry result queue. Depends on ctl_tok_pkg.
//
// The block takes one text byte per clock cycle while in_ready_o is high and splits
// it into word bytes, end-of-word marks (with the word length, held at 255),
// end-of-line marks (with the physical line index, counted from 0 over every CR
// or LF but the byte after a CR) and an end-of-input mark for byte 0. Comment lines
// (';' first), blank lines and the byte after a CR produce nothing; tab, space and
// comma split words outside double quotes. Each accepted byte is classified in the
// cycle it arrives and its zero to three results are pushed at once into the queue,
// which drains one result per cycle toward the output while out_ready_i is high.
// in_ready_o is high whenever the queue has room for three entries, so text streams
// in at one byte per cycle as long as the consumer keeps up; an end of input that
// closes a word and a line gives three results, and a stalled consumer backs up the
// input once six results wait. A byte's results enter the queue as it is accepted;
// the first reaches the outputs in the next cycle if the queue was empty. The last
// flag marks the final result caused by one input byte.
module config_text_line_tokenizer_top #(
  parameter int unsigned LineCountBits = ctl_tok_pkg::LineCountBitsDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [7:0]          in_byte_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [1:0]          kind_o,
  output logic [7:0]          word_byte_o,
  output logic [7:0]          word_length_o,
  output logic [15:0]         line_number_o,
  output logic                last_o
);

  localparam int unsigned Depth = ctl_tok_pkg::QueueDepth;
  localparam int unsigned PtrW  = $clog2(Depth);
  localparam int unsigned CntW  = $clog2(Depth + 1);
  localparam int unsigned NMax  = ctl_tok_pkg::MaxPerByte;

  // Tokenizer state.
  logic                     in_comment_q, in_comment_d;
  logic                     skip_next_q, skip_next_d;
  logic                     in_quotes_q, in_quotes_d;
  logic                     line_nonempty_q, line_nonempty_d;
  logic [7:0]               word_len_q, word_len_d;
  logic [LineCountBits-1:0] line_ctr_q, line_ctr_d;

  // Result queue.
  ctl_tok_pkg::res_t        queue_q [Depth];
  logic [PtrW-1:0]          wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]          fill_q;

  logic                     in_fire, out_fire;
  logic [1:0]               push_n;
  ctl_tok_pkg::res_t        ent [NMax];

  // Result slots in emission order: end of word, end of line or word byte,
  // end of input.
  logic                     va, vb, vc;
  ctl_tok_pkg::res_t        sa, sb, sc;

  logic [LineCountBits+15:0] line_ext;
  logic                      is_term, is_sep;

  assign in_fire  = in_valid_i && in_ready_o;
  assign out_fire = out_valid_o && out_ready_i;

  // Accept while three free entries remain.
  assign in_ready_o = (fill_q <= CntW'(Depth - NMax));

  assign line_ext = {16'b0, line_ctr_q};
  assign is_term  = (in_byte_i == ctl_tok_pkg::ChCr) || (in_byte_i == ctl_tok_pkg::ChLf);
  assign is_sep   = (in_byte_i == ctl_tok_pkg::ChTab) || (in_byte_i == ctl_tok_pkg::ChSpace)
                 || (in_byte_i == ctl_tok_pkg::ChComma);

  always_comb begin
    in_comment_d    = in_comment_q;
    skip_next_d     = skip_next_q;
    in_quotes_d     = in_quotes_q;
    line_nonempty_d = line_nonempty_q;
    word_len_d      = word_len_q;
    line_ctr_d      = line_ctr_q;
    va = 1'b0;
    vb = 1'b0;
    vc = 1'b0;
    sa = '{kind: ctl_tok_pkg::KindEow, word_byte: '0, word_length: word_len_q,
           line_number: '0, last: 1'b0};
    sb = '{kind: ctl_tok_pkg::KindEol, word_byte: '0, word_length: '0,
           line_number: line_ext[15:0], last: 1'b0};
    sc = '{kind: ctl_tok_pkg::KindEoi, word_byte: '0, word_length: '0,
           line_number: '0, last: 1'b1};

    priority if (skip_next_q) begin
      // Drop the byte after a CR, whatever it is.
      skip_next_d = 1'b0;
    end else if (in_byte_i == ctl_tok_pkg::ChNul) begin
      if (!in_comment_q) begin
        va = (word_len_q != '0);
        vb = line_nonempty_q;
      end
      vc              = 1'b1;
      in_comment_d    = 1'b0;
      in_quotes_d     = 1'b0;
      line_nonempty_d = 1'b0;
      word_len_d      = '0;
      line_ctr_d      = '0;
    end else if (is_term) begin
      if (!in_comment_q) begin
        va              = (word_len_q != '0);
        vb              = line_nonempty_q;
        word_len_d      = '0;
        line_nonempty_d = 1'b0;
        in_quotes_d     = 1'b0;
      end
      in_comment_d = 1'b0;
      skip_next_d  = (in_byte_i == ctl_tok_pkg::ChCr);
      line_ctr_d   = line_ctr_q + LineCountBits'(1);
    end else if (in_comment_q) begin
      // Drop the comment body.
    end else if ((in_byte_i == ctl_tok_pkg::ChSemi) && !line_nonempty_q) begin
      in_comment_d = 1'b1;
    end else begin
      line_nonempty_d = 1'b1;
      if (is_sep && !in_quotes_q) begin
        va         = (word_len_q != '0);
        word_len_d = '0;
      end else if (in_byte_i == ctl_tok_pkg::ChQuote) begin
        in_quotes_d = !in_quotes_q;
      end else begin
        vb = 1'b1;
        sb = '{kind: ctl_tok_pkg::KindByte, word_byte: in_byte_i, word_length: '0,
               line_number: '0, last: 1'b0};
        if (word_len_q != ctl_tok_pkg::LenMax) begin
          word_len_d = word_len_q + 8'd1;
        end
      end
    end

    // Mark the final result of this byte.
    sa.last = !vb && !vc;
    sb.last = !vc;

    // Pack the valid slots into consecutive queue entries.
    ent[0] = va ? sa : (vb ? sb : sc);
    ent[1] = (va && vb) ? sb : sc;
    ent[2] = sc;
    push_n = 2'({1'b0, va} + {1'b0, vb} + {1'b0, vc});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_comment_q    <= 1'b0;
      skip_next_q     <= 1'b0;
      in_quotes_q     <= 1'b0;
      line_nonempty_q <= 1'b0;
      word_len_q      <= '0;
      line_ctr_q      <= '0;
    end else if (in_fire) begin
      in_comment_q    <= in_comment_d;
      skip_next_q     <= skip_next_d;
      in_quotes_q     <= in_quotes_d;
      line_nonempty_q <= line_nonempty_d;
      word_len_q      <= word_len_d;
      line_ctr_q      <= line_ctr_d;
    end
  end

  // Queue storage: write up to three entries at the write pointer.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      for (int i = 0; i < NMax; i++) begin
        if (i < int'(push_n)) begin
          queue_q[wr_ptr_q + PtrW'(i)] <= ent[i];
        end
      end
    end
  end

  // Queue pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      if (in_fire) begin
        wr_ptr_q <= wr_ptr_q + PtrW'(push_n);
      end
      if (out_fire) begin
        rd_ptr_q <= rd_ptr_q + PtrW'(1);
      end
      fill_q <= fill_q + (in_fire ? CntW'(push_n) : CntW'(0)) - (out_fire ? CntW'(1) : CntW'(0));
    end
  end

  // Present the head of the queue.
  assign out_valid_o   = (fill_q != '0);
  assign kind_o        = queue_q[rd_ptr_q].kind;
  assign word_byte_o   = queue_q[rd_ptr_q].word_byte;
  assign word_length_o = queue_q[rd_ptr_q].word_length;
  assign line_number_o = queue_q[rd_ptr_q].line_number;
  assign last_o        = queue_q[rd_ptr_q].last;

  // The queue never holds more than its depth.
  assert property (@(posedge clk_i) disable iff (!rst_ni) fill_q <= CntW'(Depth))
    else $error("result queue overflow");

  // After a CR the comment flag is already cleared.
  assert property (@(posedge clk_i) disable iff (!rst_ni) !(skip_next_q && in_comment_q))
    else $error("skip after CR while in comment");

  // A comment only starts on an empty line, and comment bytes never fill it.
  assert property (@(posedge clk_i) disable iff (!rst_ni) !(in_comment_q && line_nonempty_q))
    else $error("comment on a nonempty line");

  // A word in progress implies the line holds bytes.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
      (word_len_q != '0) |-> line_nonempty_q)
    else $error("word open on empty line");

endmodule

// ===== bench/config_text_line_tokenizer_checker.sv =====
`timescale 1ns / 100ps
// Scoreboard for the configuration text tokenizer: watches both channels, predicts the
// results of every accepted text byte and compares them in order. Depends on ctl_tok_pkg.
module config_text_line_tokenizer_checker #(
  parameter int unsigned LineCountBits = ctl_tok_pkg::LineCountBitsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic [7:0]  in_byte_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic [1:0]  kind_i,
  input  logic [7:0]  word_byte_i,
  input  logic [7:0]  word_length_i,
  input  logic [15:0] line_number_i,
  input  logic        last_i,
  output int          fail_count_o,
  output int          pending_o
);

  ctl_tok_pkg::res_t pending_tokens[$];

  logic                     comment_skip;
  logic                     drop_after_cr;
  logic                     quoting;
  logic                     line_has_bytes;
  logic [7:0]               cur_word_len;
  logic [LineCountBits-1:0] phys_line;

  int fails = 0;
  assign fail_count_o = fails;

  task automatic clear_state();
    comment_skip   = 1'b0;
    drop_after_cr  = 1'b0;
    quoting        = 1'b0;
    line_has_bytes = 1'b0;
    cur_word_len   = '0;
    phys_line      = '0;
  endtask

  task automatic emit(input ctl_tok_pkg::kind_e k, input logic [7:0] wb,
                      input logic [7:0] wl, input logic [15:0] ln);
    ctl_tok_pkg::res_t r;
    r.kind        = k;
    r.word_byte   = wb;
    r.word_length = wl;
    r.line_number = ln;
    r.last        = 1'b0;
    pending_tokens.push_back(r);
  endtask

  task automatic end_line();
    if (cur_word_len != 0) emit(ctl_tok_pkg::KindEow, 8'd0, cur_word_len, 16'd0);
    if (line_has_bytes) emit(ctl_tok_pkg::KindEol, 8'd0, 8'd0, 16'(phys_line));
    cur_word_len   = '0;
    line_has_bytes = 1'b0;
    quoting        = 1'b0;
  endtask

  task automatic tokenize_byte(input logic [7:0] ch);
    int first;
    first = pending_tokens.size();
    if (drop_after_cr) begin
      drop_after_cr = 1'b0;
    end else if (ch == ctl_tok_pkg::ChNul) begin
      if (!comment_skip) end_line();
      emit(ctl_tok_pkg::KindEoi, 8'd0, 8'd0, 16'd0);
      clear_state();
    end else if (ch == ctl_tok_pkg::ChCr || ch == ctl_tok_pkg::ChLf) begin
      if (!comment_skip) end_line();
      comment_skip  = 1'b0;
      drop_after_cr = (ch == ctl_tok_pkg::ChCr);
      phys_line     = phys_line + 1'b1;
    end else if (comment_skip) begin
      // drop comment body
    end else if (ch == ctl_tok_pkg::ChSemi && !line_has_bytes) begin
      comment_skip = 1'b1;
    end else begin
      line_has_bytes = 1'b1;
      if ((ch == ctl_tok_pkg::ChTab || ch == ctl_tok_pkg::ChSpace
           || ch == ctl_tok_pkg::ChComma) && !quoting) begin
        if (cur_word_len != 0) begin
          emit(ctl_tok_pkg::KindEow, 8'd0, cur_word_len, 16'd0);
          cur_word_len = '0;
        end
      end else if (ch == ctl_tok_pkg::ChQuote) begin
        quoting = !quoting;
      end else begin
        emit(ctl_tok_pkg::KindByte, ch, 8'd0, 16'd0);
        if (cur_word_len != ctl_tok_pkg::LenMax) cur_word_len = cur_word_len + 1'b1;
      end
    end
    if (pending_tokens.size() > first) pending_tokens[pending_tokens.size()-1].last = 1'b1;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    ctl_tok_pkg::res_t want;
    if (!rst_ni) begin
      clear_state();
      pending_tokens.delete();
      pending_o = 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (pending_tokens.size() == 0) begin
          $error("unexpected result: kind %0d byte %0d length %0d line %0d",
                 kind_i, word_byte_i, word_length_i, line_number_i);
          fails++;
        end else begin
          want = pending_tokens.pop_front();
          if (kind_i !== want.kind) begin
            $error("kind: expected %0d, got %0d", want.kind, kind_i);
            fails++;
          end
          if (word_byte_i !== want.word_byte) begin
            $error("word_byte: expected %0d, got %0d", want.word_byte, word_byte_i);
            fails++;
          end
          if (word_length_i !== want.word_length) begin
            $error("word_length: expected %0d, got %0d", want.word_length, word_length_i);
            fails++;
          end
          if (line_number_i !== want.line_number) begin
            $error("line_number: expected %0d, got %0d", want.line_number, line_number_i);
            fails++;
          end
          if (last_i !== want.last) begin
            $error("last: expected %0d, got %0d", want.last, last_i);
            fails++;
          end
        end
      end
      if (in_valid_i && in_ready_i) tokenize_byte(in_byte_i);
      pending_o = pending_tokens.size();
    end
  end

endmodule

// ===== bench/config_text_line_tokenizer_top_test.sv =====
`timescale 1ns / 100ps
// Top of the tokenizer regression: clock, reset, text stimulus and the verdict.
// Depends on ctl_tok_pkg, config_text_line_tokenizer_top and the tokenizer scoreboard.
module config_text_line_tokenizer_top_test;

  localparam int unsigned LineBits    = 16;
  localparam int          RandomItems = 200;
  // A clean run sends about 230 bytes and ends long before this limit.
  localparam int          CycleLimit  = 20000;
  localparam int          DrainCycles = 16;

  logic        clk       = 1'b0;
  logic        rst_n     = 1'b0;
  logic        in_valid  = 1'b0;
  logic [7:0]  in_byte   = 8'd0;
  logic        out_ready = 1'b0;
  logic        in_ready;
  logic        out_valid;
  logic [1:0]  kind;
  logic [7:0]  word_byte;
  logic [7:0]  word_length;
  logic [15:0] line_number;
  logic        last;

  int fail_count;
  int pending;
  int cycle_count = 0;
  int bytes_sent  = 0;
  bit gaps_on     = 1'b1;

  config_text_line_tokenizer_top #(
    .LineCountBits(LineBits)
  ) dut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_ready_o   (in_ready),
    .in_byte_i    (in_byte),
    .out_valid_o  (out_valid),
    .out_ready_i  (out_ready),
    .kind_o       (kind),
    .word_byte_o  (word_byte),
    .word_length_o(word_length),
    .line_number_o(line_number),
    .last_o       (last)
  );

  config_text_line_tokenizer_checker #(
    .LineCountBits(LineBits)
  ) token_monitor (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_ready_i   (in_ready),
    .in_byte_i    (in_byte),
    .out_valid_i  (out_valid),
    .out_ready_i  (out_ready),
    .kind_i       (kind),
    .word_byte_i  (word_byte),
    .word_length_i(word_length),
    .line_number_i(line_number),
    .last_i       (last),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Bound the run: a hang anywhere ends here.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Stall the result side at random, with a chance of about one in ten, unless a quiet stretch is on.
  always @(negedge clk) begin
    out_ready <= !(gaps_on && $urandom_range(0, 99) < 10);
  end

  // Offer one input byte: called at a falling edge, returns at the falling edge after
  // the byte is taken. Insert random gaps first, then hold valid and payload until accepted.
  task automatic send_byte(input logic [7:0] b);
    while (gaps_on && $urandom_range(0, 99) < 10) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_byte  <= b;
    do @(posedge clk); while (!in_ready);
    bytes_sent++;
    @(negedge clk);
  endtask

  function automatic logic [7:0] pick_sep();
    case ($urandom_range(0, 2))
      0:       return ctl_tok_pkg::ChTab;
      1:       return ctl_tok_pkg::ChSpace;
      default: return ctl_tok_pkg::ChComma;
    endcase
  endfunction

  // Mostly lower-case letters, sometimes any byte that is not a separator, quote or break.
  function automatic logic [7:0] pick_word_char();
    logic [7:0] c;
    if ($urandom_range(0, 9) < 7) return 8'h61 + 8'($urandom_range(0, 25));
    do c = 8'($urandom_range(1, 255));
    while (c inside {ctl_tok_pkg::ChTab, ctl_tok_pkg::ChLf, ctl_tok_pkg::ChCr,
                     ctl_tok_pkg::ChSpace, ctl_tok_pkg::ChQuote, ctl_tok_pkg::ChComma});
    return c;
  endfunction

  // Anything but a line break or end of input, so a comment body runs to its terminator.
  function automatic logic [7:0] pick_body_char();
    logic [7:0] c;
    do c = 8'($urandom_range(1, 255));
    while (c == ctl_tok_pkg::ChLf || c == ctl_tok_pkg::ChCr);
    return c;
  endfunction

  // End a line with LF, CR plus an arbitrary swallowed byte, or end of input.
  task automatic send_line_end();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) begin
      send_byte(ctl_tok_pkg::ChLf);
    end else if (r < 90) begin
      send_byte(ctl_tok_pkg::ChCr);
      send_byte(8'($urandom_range(0, 255)));
    end else begin
      send_byte(ctl_tok_pkg::ChNul);
    end
  endtask

  initial begin
    logic [7:0] directed_text[$];
    int         line_kind;
    int         nwords;
    int         wlen;
    int         line_no;
    int         rand_start;
    bit         quoted;

    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed text: every separator, quoting with a space inside, an empty quoted word,
    // CR with a swallowed 0 behind it, a comment line, a blank line, a separators-only line,
    // a semicolon past the start, the byte extremes, an open word and open quote cut off by
    // end of input, a comment cut off by end of input, and end of input on its own.
    directed_text = '{
      "a", ctl_tok_pkg::ChComma, "b", ctl_tok_pkg::ChTab, "c", ctl_tok_pkg::ChSpace,
      ctl_tok_pkg::ChQuote, "d", ctl_tok_pkg::ChSpace, ctl_tok_pkg::ChQuote,
      ctl_tok_pkg::ChQuote, ctl_tok_pkg::ChQuote, ctl_tok_pkg::ChCr, ctl_tok_pkg::ChNul,
      ctl_tok_pkg::ChSemi, "x", ctl_tok_pkg::ChLf,
      ctl_tok_pkg::ChLf,
      ctl_tok_pkg::ChComma, ctl_tok_pkg::ChLf,
      "x", ctl_tok_pkg::ChSemi, ctl_tok_pkg::ChLf,
      8'hFF, 8'h01, ctl_tok_pkg::ChQuote, "q", ctl_tok_pkg::ChNul,
      ctl_tok_pkg::ChSemi, ctl_tok_pkg::ChNul,
      ctl_tok_pkg::ChNul
    };
    foreach (directed_text[i]) send_byte(directed_text[i]);

    // Random text: mostly lines of words, with comments, blank lines and raw noise mixed in.
    rand_start = bytes_sent;
    line_no    = 0;
    while (bytes_sent - rand_start < RandomItems) begin
      // Hold both sides steady for a stretch of lines.
      gaps_on   = !(line_no >= 12 && line_no < 24);
      line_kind = $urandom_range(0, 99);
      if (line_kind < 60) begin
        nwords = $urandom_range(1, 4);
        if ($urandom_range(0, 3) == 0) send_byte(pick_sep());
        for (int w = 0; w < nwords; w++) begin
          if (w > 0) repeat ($urandom_range(1, 2)) send_byte(pick_sep());
          quoted = ($urandom_range(0, 4) == 0);
          if (quoted) send_byte(ctl_tok_pkg::ChQuote);
          wlen = $urandom_range(quoted ? 0 : 1, 8);
          repeat (wlen) begin
            if (quoted && $urandom_range(0, 3) == 0) send_byte(pick_sep());
            else send_byte(pick_word_char());
          end
          // Leave a quote open now and then; the line end closes it.
          if (quoted && $urandom_range(0, 5) != 0) send_byte(ctl_tok_pkg::ChQuote);
        end
      end else if (line_kind < 72) begin
        send_byte(ctl_tok_pkg::ChSemi);
        repeat ($urandom_range(0, 8)) send_byte(pick_body_char());
      end else if (line_kind >= 80) begin
        repeat ($urandom_range(1, 12)) send_byte(8'($urandom_range(1, 255)));
      end
      send_line_end();
      line_no++;
    end
    gaps_on = 1'b1;
    send_byte(ctl_tok_pkg::ChNul);

    in_valid <= 1'b0;

    // Drain: wait until every predicted result has come, then keep watching the outputs
    // for anything extra.
    while (pending != 0) @(negedge clk);
    repeat (DrainCycles) @(negedge clk);

    if (fail_count == 0 && pending == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
